[src/olst_pkg.sv]
// Shared types and constants of the ordered list engine.
package olst_pkg;

  localparam int OLST_CAPACITY = 1024;
  localparam int REQ_W         = 3;
  localparam int POS_W         = 11;
  localparam int VAL_W         = 32;
  localparam int STAT_W        = 2;
  localparam int IDX_W         = 11;
  localparam int CNT_W         = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_POP_BACK   = 3'd1,
    REQ_PUSH_FRONT = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_ERASE      = 3'd5,
    REQ_FIND       = 3'd6
  } olst_req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } olst_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_FIND,
    S_RESULT
  } olst_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic start;
    logic up_rd;
    logic dn_rd;
    logic find_rd;
    logic put_val;
    logic cnt_inc;
    logic cnt_dec;
    logic hit;
    logic publish;
  } olst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    olst_req_e    kind;
    olst_status_e status;
    logic         err;
    logic         up_more;
    logic         dn_more;
    logic         hit;
    logic         mv_busy;
    logic         out_busy;
  } olst_sts_t;

endpackage

[src/olst_req_if.sv]
// Request channel of the ordered list engine.
interface olst_req_if;
  import olst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

[src/olst_rsp_if.sv]
// Result channel of the ordered list engine.
interface olst_rsp_if;
  import olst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic                    found;
  logic signed [IDX_W-1:0] found_index;
  logic [CNT_W-1:0]        count;

  modport source (output valid, status, found, found_index, count, input ready);
  modport sink   (input valid, status, found, found_index, count, output ready);
endinterface

[src/olst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module olst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[src/olst_ctrl.sv]
// Controller state machine of the ordered list engine.
module olst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  olst_pkg::olst_sts_t sts_i,
  output olst_pkg::olst_cmd_t cmd_o
);
  import olst_pkg::*;

  olst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.err) begin
          state_d = S_RESULT;
        end else begin
          case (sts_i.kind)
            REQ_PUSH_FRONT, REQ_INSERT: state_d = S_SHIFT_UP;
            REQ_POP_FRONT, REQ_ERASE:   state_d = S_SHIFT_DN;
            REQ_FIND:                   state_d = S_FIND;
            default:                    state_d = S_RESULT;
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (!sts_i.up_more) state_d = S_PUT;
      end
      S_PUT: state_d = S_RESULT;
      S_SHIFT_DN: begin
        if (!sts_i.dn_more) state_d = S_RESULT;
      end
      S_FIND: begin
        if (sts_i.hit || !sts_i.dn_more) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (!sts_i.err) begin
          case (sts_i.kind)
            REQ_PUSH_BACK: begin
              cmd_o.put_val = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
            REQ_POP_BACK: cmd_o.cnt_dec = 1'b1;
            REQ_PUSH_FRONT, REQ_INSERT, REQ_POP_FRONT, REQ_ERASE, REQ_FIND: begin
              cmd_o.start = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT_UP: cmd_o.up_rd = sts_i.up_more;
      S_PUT: begin
        cmd_o.put_val = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_SHIFT_DN: begin
        // The last moved entry is written back in the same cycle as the count drops.
        cmd_o.dn_rd   = sts_i.dn_more;
        cmd_o.cnt_dec = !sts_i.dn_more;
      end
      S_FIND: begin
        cmd_o.hit     = sts_i.hit;
        cmd_o.find_rd = !sts_i.hit && sts_i.dn_more;
      end
      S_RESULT: cmd_o.publish = !sts_i.out_busy;
      default: ;
    endcase
  end
endmodule

[src/olst_datapath.sv]
// Datapath of the ordered list engine: entry store, count, walk pointer and result registers.
module olst_datapath #(
  parameter int CAPACITY = olst_pkg::OLST_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  olst_pkg::olst_cmd_t               cmd_i,
  output olst_pkg::olst_sts_t               sts_o,
  input  logic [olst_pkg::REQ_W-1:0]        req_type_i,
  input  logic [olst_pkg::POS_W-1:0]        position_i,
  input  logic signed [olst_pkg::VAL_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [olst_pkg::STAT_W-1:0]       status_o,
  output logic                              found_o,
  output logic signed [olst_pkg::IDX_W-1:0] found_index_o,
  output logic [olst_pkg::CNT_W-1:0]        count_o
);
  import olst_pkg::*;

  localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  olst_req_e               req_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           ptr_q, ptr_d;
  logic                    mv_pend_q;
  logic [AW-1:0]           mv_wa_q;
  logic                    cmp_pend_q;
  logic [CW-1:0]           cmp_idx_q;
  olst_status_e            status_q, status_c;
  logic                    found_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       rsp_status_q;
  logic                    rsp_found_q;
  logic [IDX_W-1:0]        rsp_idx_q;
  logic [CNT_W-1:0]        rsp_cnt_q;

  logic [MW-1:0]    cnt_x, pos_x, at_x, cap_x;
  logic             full, empty, up_kind;
  logic [AW-1:0]    rd_addr, put_addr, waddr;
  logic             we;
  logic [VAL_W-1:0] wdata, rdata;
  logic             hit;

  assign cnt_x   = MW'(cnt_q);
  assign pos_x   = MW'(pos_q);
  assign cap_x   = MW'(CAPACITY);
  assign full    = cnt_x >= cap_x;
  assign empty   = cnt_q == '0;
  assign up_kind = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_INSERT);
  // Front operations work at index zero; insert and erase at the given position.
  assign at_x    = ((req_q == REQ_PUSH_FRONT) || (req_q == REQ_POP_FRONT)) ? '0 : pos_x;

  always_comb begin
    status_c = STAT_OK;
    case (req_q)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: if (full) status_c = STAT_FULL;
      REQ_POP_BACK, REQ_POP_FRONT:   if (empty) status_c = STAT_EMPTY;
      REQ_INSERT: begin
        if (pos_x > cnt_x)  status_c = STAT_RANGE;
        else if (full)      status_c = STAT_FULL;
      end
      REQ_ERASE: begin
        if (empty)               status_c = STAT_EMPTY;
        else if (pos_x >= cnt_x) status_c = STAT_RANGE;
      end
      default: status_c = STAT_OK;
    endcase
  end

  assign hit = cmp_pend_q && (rdata == val_q);

  always_comb begin
    sts_o          = '0;
    sts_o.kind     = req_q;
    sts_o.status   = status_c;
    sts_o.err      = status_c != STAT_OK;
    sts_o.up_more  = MW'(ptr_q) > at_x;
    sts_o.dn_more  = ptr_q < cnt_q;
    sts_o.hit      = hit;
    sts_o.mv_busy  = mv_pend_q;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  // Walk pointer: counts down while opening a gap, up while closing one or searching.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.start) begin
      if (up_kind)                ptr_d = cnt_q;
      else if (req_q == REQ_FIND) ptr_d = '0;
      else                        ptr_d = CW'(at_x + MW'(1));
    end else if (cmd_i.up_rd) begin
      ptr_d = ptr_q - CW'(1);
    end else if (cmd_i.dn_rd || cmd_i.find_rd) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc)      cnt_d = cnt_q + CW'(1);
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - CW'(1);
  end

  assign rd_addr  = cmd_i.up_rd ? AW'(ptr_q - CW'(1)) : AW'(ptr_q);
  assign put_addr = (req_q == REQ_PUSH_BACK) ? AW'(cnt_q) : AW'(at_x);
  // A pending move writes the entry read in the previous cycle.
  assign we       = mv_pend_q || cmd_i.put_val;
  assign waddr    = mv_pend_q ? mv_wa_q : put_addr;
  assign wdata    = mv_pend_q ? rdata : val_q;

  olst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mv_pend_q   <= 1'b0;
      cmp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      mv_pend_q  <= cmd_i.up_rd || cmd_i.dn_rd;
      cmp_pend_q <= cmd_i.find_rd;
      if (cmd_i.publish)    out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      req_q   <= olst_req_e'(req_type_i);
      pos_q   <= position_i;
      val_q   <= value_i;
      found_q <= 1'b0;
      idx_q   <= '1;
    end
    if (cmd_i.decode) status_q <= status_c;
    if (cmd_i.up_rd)  mv_wa_q <= AW'(ptr_q);
    if (cmd_i.dn_rd)  mv_wa_q <= AW'(ptr_q - CW'(1));
    if (cmd_i.find_rd) cmp_idx_q <= ptr_q;
    if (cmd_i.hit) begin
      found_q <= 1'b1;
      idx_q   <= IDX_W'(cmp_idx_q);
    end
    if (cmd_i.publish) begin
      rsp_status_q <= status_q;
      rsp_found_q  <= found_q;
      rsp_idx_q    <= idx_q;
      rsp_cnt_q    <= CNT_W'(cnt_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = rsp_status_q;
  assign found_o       = rsp_found_q;
  assign found_index_o = rsp_idx_q;
  assign count_o       = rsp_cnt_q;
endmodule

[src/ordered_list_engine.sv]
// Ordered list engine: an ordered list of signed 32-bit values with push, pop, insert,
// erase and find requests, one result for each request.
// Requests enter on req_i (valid/ready) and results leave on rsp_o (valid/ready); one
// request is worked on at a time, and ready is high only while the engine is idle.
// Push front and insert walk the entries from the end down to the position; pop front
// and erase walk from the position up to the end; find walks from index zero until a
// match or the end. Push back, pop back, unknown or refused requests need no walk.
// The walk reads one RAM entry each cycle and writes one each cycle while moving entries.
// The result sits in an output register: a new request is taken while it waits, and the
// engine holds in its result state only if the earlier result has still not been taken.
// A stalled receiver therefore stalls the engine after at most one further request.
// Reset empties the list at once; the entry RAM is not cleared, since no entry is read
// before it has been written.
module ordered_list_engine #(
  parameter int CAPACITY = olst_pkg::OLST_CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  olst_req_if.sink     req_i,
  olst_rsp_if.source   rsp_o
);
  import olst_pkg::*;

  olst_cmd_t cmd;
  olst_sts_t sts;

  olst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .position_i    (req_i.position),
    .value_i       (req_i.value),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .found_o       (rsp_o.found),
    .found_index_o (rsp_o.found_index),
    .count_o       (rsp_o.count)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("engine took a request while still busy");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.put_val && sts.mv_busy))
    else $error("value write collides with a pending entry move");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> rsp_o.valid)
    else $error("published result not presented");

  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cnt_inc || cmd.cnt_dec) |-> (sts.status == STAT_OK))
    else $error("count changed on a refused request");
endmodule

[bench/testbench.sv]
// Self-checking testbench of the ordered list engine: a list tracker predicts and checks results.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import olst_pkg::*;

  // The block ignores this request code and answers with the count unchanged.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct {
    olst_status_e            status;
    logic                    found;
    logic signed [IDX_W-1:0] hit_index;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  // Keeps its own copy of the list and the results still owed by the block.
  class list_tracker;
    int unsigned             capacity;
    logic signed [VAL_W-1:0] entries_q[$];
    list_result_t            owed_q[$];
    int                      errors;
    int                      checked;
    int                      taken;
    int                      peak;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    function int length();
      return entries_q.size();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic signed [VAL_W-1:0] entry_at(int idx);
      return entries_q[idx];
    endfunction

    function void take_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      list_result_t r;
      int           n;
      n           = entries_q.size();
      r.status    = STAT_OK;
      r.found     = 1'b0;
      r.hit_index = '1;
      case (kind)
        REQ_PUSH_BACK: begin
          if (n >= capacity) r.status = STAT_FULL;
          else entries_q.push_back(val);
        end
        REQ_POP_BACK: begin
          if (n == 0) r.status = STAT_EMPTY;
          else void'(entries_q.pop_back());
        end
        REQ_PUSH_FRONT: begin
          if (n >= capacity) r.status = STAT_FULL;
          else entries_q.push_front(val);
        end
        REQ_POP_FRONT: begin
          if (n == 0) r.status = STAT_EMPTY;
          else void'(entries_q.pop_front());
        end
        REQ_INSERT: begin
          // The range check takes precedence over the full check.
          if (int'(pos) > n) r.status = STAT_RANGE;
          else if (n >= capacity) r.status = STAT_FULL;
          else entries_q.insert(int'(pos), val);
        end
        REQ_ERASE: begin
          if (n == 0) r.status = STAT_EMPTY;
          else if (int'(pos) >= n) r.status = STAT_RANGE;
          else entries_q.delete(int'(pos));
        end
        REQ_FIND: begin
          for (int i = 0; i < n; i++) begin
            if (!r.found && entries_q[i] == val) begin
              r.found     = 1'b1;
              r.hit_index = IDX_W'(i);
            end
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(entries_q.size());
      if (entries_q.size() > peak) peak = entries_q.size();
      owed_q.push_back(r);
      taken++;
    endfunction

    function void field_check(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic found,
                               logic signed [IDX_W-1:0] hit_index, logic [CNT_W-1:0] count);
      list_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual status %0d count %0d",
                 $time, status, count);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      field_check("status", 32'(want.status), 32'(status));
      field_check("found", 32'(want.found), 32'(found));
      field_check("found_index", 32'(want.hit_index), 32'(hit_index));
      field_check("count", 32'(want.count), 32'(count));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        hold_on = 1'b0;
  int          send_idle = 0;
  int          rsp_stall = 0;
  int          cycles = 0;
  event        long_hold;
  list_tracker tracker = new(OLST_CAPACITY);

  olst_req_if req_if ();
  olst_rsp_if rsp_if ();

  ordered_list_engine u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, tracker.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted in falling edges.
  always begin
    @(long_hold);
    hold_on = 1'b1;
    repeat (300) @(negedge clk);
    hold_on = 1'b0;
  end

  // Receiver: a long hold-off takes precedence over the random stall.
  always @(negedge clk) begin
    if (hold_on) begin
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= rsp_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      tracker.check_result(rsp_if.status, rsp_if.found, rsp_if.found_index, rsp_if.count);
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = kind;
    req_if.position = pos;
    req_if.value    = val;
    do @(posedge clk); while (!req_if.ready);
    tracker.take_request(kind, pos, val);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Mostly legal positions, with some just past the end and some anywhere in the field.
  function automatic logic [POS_W-1:0] pick_position(int top);
    int roll;
    roll = $urandom_range(19);
    if (roll < 17 && top >= 0) return POS_W'($urandom_range(top));
    if (roll < 19) return POS_W'(top + 1 + int'($urandom_range(3)));
    return POS_W'($urandom_range(2047));
  endfunction

  // Growth is favored on a short list and shrinking on a long one, so the list stays small.
  task automatic pick_request(output logic [REQ_W-1:0] kind, output logic [POS_W-1:0] pos,
                              output logic signed [VAL_W-1:0] val);
    int n;
    int grow;
    int roll;
    n    = tracker.length();
    grow = (n < 6) ? 60 : ((n > 40) ? 25 : 45);
    roll = $urandom_range(99);
    pos  = POS_W'($urandom_range(2047));
    if ($urandom_range(3) == 0) val = $urandom;
    else val = int'($urandom_range(7)) - 4;
    if (roll < 2) begin
      kind = REQ_UNKNOWN;
    end else if (roll < grow) begin
      case ($urandom_range(2))
        0: kind = REQ_PUSH_BACK;
        1: kind = REQ_PUSH_FRONT;
        default: begin
          kind = REQ_INSERT;
          pos  = pick_position(n);
        end
      endcase
    end else if (roll < grow + (100 - grow) * 2 / 3) begin
      case ($urandom_range(2))
        0: kind = REQ_POP_BACK;
        1: kind = REQ_POP_FRONT;
        default: begin
          kind = REQ_ERASE;
          pos  = pick_position(n - 1);
        end
      endcase
    end else begin
      kind = REQ_FIND;
      if (n > 0 && $urandom_range(9) < 6) val = tracker.entry_at($urandom_range(n - 1));
    end
  endtask

  task automatic run_random(input int amount, input int idle, input int stall);
    logic [REQ_W-1:0]        kind;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      sent;
    send_idle = idle;
    rsp_stall = stall;
    sent      = 0;
    while (sent < amount) begin
      pick_request(kind, pos, val);
      send_request(kind, pos, val);
      if (kind != REQ_UNKNOWN) sent++;
    end
    wait_drained();
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH_BACK;
    req_if.position = '0;
    req_if.value    = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Empty list, both ends of the value range, duplicates and the empty and range refusals.
    send_request(REQ_POP_BACK, 11'd0, 32'sd0);
    send_request(REQ_POP_FRONT, 11'd0, 32'sd0);
    send_request(REQ_ERASE, 11'd0, 32'sd0);
    send_request(REQ_ERASE, 11'd2047, 32'sd0);
    send_request(REQ_FIND, 11'd0, 32'sd0);
    send_request(REQ_INSERT, 11'd1, 32'sd9);
    send_request(REQ_INSERT, 11'd0, 32'sh8000_0000);
    send_request(REQ_PUSH_BACK, 11'd0, 32'sh7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 11'd0, -32'sd1);
    send_request(REQ_PUSH_BACK, 11'd0, 32'sd0);
    send_request(REQ_INSERT, 11'd4, 32'sd5);
    send_request(REQ_INSERT, 11'd2, 32'sd5);
    send_request(REQ_FIND, 11'd0, 32'sd5);
    send_request(REQ_FIND, 11'd0, 32'sh7FFF_FFFF);
    send_request(REQ_FIND, 11'd0, 32'sd12345);
    send_request(REQ_UNKNOWN, 11'd3, 32'sd1);
    send_request(REQ_INSERT, 11'd2047, 32'sd1);
    send_request(REQ_INSERT, 11'd7, 32'sd1);
    send_request(REQ_ERASE, 11'd6, 32'sd0);
    send_request(REQ_ERASE, 11'd2, 32'sd0);
    send_request(REQ_POP_FRONT, 11'd0, 32'sd0);
    send_request(REQ_POP_BACK, 11'd0, 32'sd0);
    send_request(REQ_FIND, 11'd0, 32'sh8000_0000);
    wait_drained();

    run_random(125, 0, 0);
    run_random(125, 67, 0);
    // The receiver holds off while requests keep coming, so the engine backs up.
    -> long_hold;
    run_random(125, 0, 67);
    run_random(125, 17, 17);

    // Fill to capacity, then exercise the full list at both ends and in the middle.
    send_idle = 0;
    rsp_stall = 0;
    while (tracker.length() < OLST_CAPACITY)
      send_request(REQ_PUSH_BACK, POS_W'($urandom_range(2047)), $urandom);
    send_request(REQ_PUSH_BACK, 11'd0, 32'sd1);
    send_request(REQ_PUSH_FRONT, 11'd0, 32'sd1);
    send_request(REQ_INSERT, 11'd1024, 32'sd1);
    send_request(REQ_INSERT, 11'd1025, 32'sd1);
    send_request(REQ_INSERT, 11'd0, 32'sd1);
    send_request(REQ_FIND, 11'd0, tracker.entry_at(OLST_CAPACITY - 1));
    send_request(REQ_FIND, 11'd0, $urandom);
    send_request(REQ_ERASE, 11'd1023, 32'sd0);
    send_request(REQ_ERASE, 11'd1023, 32'sd0);
    send_request(REQ_POP_FRONT, 11'd0, 32'sd0);
    send_request(REQ_PUSH_FRONT, 11'd0, 32'sd77);
    send_request(REQ_INSERT, 11'd512, 32'sd78);
    send_request(REQ_POP_BACK, 11'd0, 32'sd0);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Checked %0d results of %0d requests under four idle and stall mixes;",
             tracker.checked, tracker.taken);
    $display("the list grew to %0d entries, up to full capacity.", tracker.peak);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[ordered_list_engine.f]
src/olst_pkg.sv
src/olst_req_if.sv
src/olst_rsp_if.sv
src/olst_ram.sv
src/olst_ctrl.sv
src/olst_datapath.sv
src/ordered_list_engine.sv
bench/testbench.sv
